[sv/bls_pkg.sv]
// shared types, codes and constants of the bresenham line stepper
package bls_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int DIM_BITS           = 15;
  localparam int LEFT_BITS          = 16;
  localparam int CFG_ADDR_BITS      = 8;
  localparam int CFG_DATA_BITS      = 16;

  localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = 15'd640;
  localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = 15'd480;

  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_STARTED  = 2'd0,
    STATUS_STEPPED  = 2'd1,
    STATUS_REJECTED = 2'd2,
    STATUS_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic x_negative;
    logic y_negative;
    logic x_is_major;
  } line_dir_t;

endpackage

[sv/bls_req_if.sv]
// request channel: start or advance transactions with line endpoints
interface bls_req_if #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] begin_x;
  logic signed [COORD_BITS-1:0] begin_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, req_type, begin_x, begin_y, end_x, end_y, input ready);
  modport sink   (input valid, req_type, begin_x, begin_y, end_x, end_y, output ready);
endinterface

[sv/bls_rsp_if.sv]
// response channel: one pixel transaction per request
interface bls_rsp_if #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
);
  logic                             valid;
  logic                             ready;
  logic signed [COORD_BITS-1:0]     pixel_x;
  logic signed [COORD_BITS-1:0]     pixel_y;
  logic [1:0]                       status;
  logic [bls_pkg::LEFT_BITS-1:0]    pixels_left;
  logic                             is_last;

  modport source (output valid, pixel_x, pixel_y, status, pixels_left, is_last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, status, pixels_left, is_last, output ready);
endinterface

[sv/bls_cfg_if.sv]
// configuration write channel
interface bls_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bls_pkg::CFG_ADDR_BITS-1:0]   addr;
  logic [bls_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[sv/bresenham_line_stepper_unit.sv]
// top level of the bresenham line pixel stepper
//
// Bresenham line stepper. A start transaction carries two endpoints; if both
// lie outside the image (0 <= x < image_width, 0 <= y < image_height) the line
// is rejected, otherwise drawing begins at the endpoint that is inside and the
// first point is returned along with the number of steps left on the major
// axis (x is major only when |dx| > |dy|). Each advance transaction makes one
// step and returns the next point; is_last marks the final pixel, and an
// advance with no active line returns the current point with status "no
// active line". Coordinates wrap modulo 2^COORD_BITS. Throughput is one
// transaction per clock while the response side takes results: a request is
// taken into an input register, the start decode or the single
// add/compare/subtract of the step runs combinationally, and the result
// lands in an output register. The start decode, a subtract, an absolute
// value and a compare in a row, is the longest path. The
// response register lets a new request enter while a result waits to be
// taken; ready drops only when both registers are full and the response side
// is stalled. Configuration writes are always accepted and should be issued
// only while no transaction is in flight.
module bresenham_line_stepper_unit #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  bls_req_if.sink req,
  bls_rsp_if.source rsp,
  bls_cfg_if.sink cfg
);
  // image size registers
  logic [bls_pkg::DIM_BITS-1:0] image_width;
  logic [bls_pkg::DIM_BITS-1:0] image_height;

  // input register
  logic                         s1_valid;
  bls_pkg::req_type_t           s1_req_type;
  logic signed [COORD_BITS-1:0] s1_begin_x;
  logic signed [COORD_BITS-1:0] s1_begin_y;
  logic signed [COORD_BITS-1:0] s1_end_x;
  logic signed [COORD_BITS-1:0] s1_end_y;
  logic                         s1_fire;

  // line state
  logic signed [COORD_BITS-1:0] cur_x,         cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y,         cur_y_next;
  logic signed [COORD_BITS+1:0] err_acc,       err_acc_next;
  logic [COORD_BITS:0]          delta_major,   delta_major_next;
  logic [COORD_BITS:0]          delta_minor,   delta_minor_next;
  bls_pkg::line_dir_t           dir,           dir_next;
  logic [COORD_BITS:0]          remaining,     remaining_next;
  logic                         line_active,   line_active_next;

  // response register
  logic                          out_valid;
  logic signed [COORD_BITS-1:0]  out_x,      out_x_next;
  logic signed [COORD_BITS-1:0]  out_y,      out_y_next;
  bls_pkg::status_t              out_status, out_status_next;
  logic [bls_pkg::LEFT_BITS-1:0] out_left,   out_left_next;
  logic                          out_last,   out_last_next;

  // start decode results
  logic                         su_accepted;
  logic signed [COORD_BITS-1:0] su_x;
  logic signed [COORD_BITS-1:0] su_y;
  bls_pkg::line_dir_t           su_dir;
  logic [COORD_BITS:0]          su_major;
  logic [COORD_BITS:0]          su_minor;

  // step results
  logic signed [COORD_BITS-1:0] adv_x;
  logic signed [COORD_BITS-1:0] adv_y;
  logic signed [COORD_BITS+1:0] adv_err;
  logic [COORD_BITS:0]          adv_remaining;
  logic                         adv_done;

  // handshakes: the work stage moves when the response register is free or emptying
  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.pixel_x     = out_x;
  assign rsp.pixel_y     = out_y;
  assign rsp.status      = out_status;
  assign rsp.pixels_left = out_left;
  assign rsp.is_last     = out_last;

  // configuration writes; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bls_pkg::IMAGE_WIDTH_RESET;
      image_height <= bls_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg.valid) begin
      if (cfg.addr == bls_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg.data[bls_pkg::DIM_BITS-1:0];
      end
      if (cfg.addr == bls_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg.data[bls_pkg::DIM_BITS-1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req_type <= bls_pkg::req_type_t'(req.req_type);
      s1_begin_x  <= req.begin_x;
      s1_begin_y  <= req.begin_y;
      s1_end_x    <= req.end_x;
      s1_end_y    <= req.end_y;
    end
  end

  bls_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .begin_x      (s1_begin_x),
    .begin_y      (s1_begin_y),
    .end_x        (s1_end_x),
    .end_y        (s1_end_y),
    .image_width  (image_width),
    .image_height (image_height),
    .accepted     (su_accepted),
    .org_x        (su_x),
    .org_y        (su_y),
    .dir          (su_dir),
    .delta_major  (su_major),
    .delta_minor  (su_minor)
  );

  bls_advance #(
    .COORD_BITS (COORD_BITS)
  ) u_advance (
    .cur_x          (cur_x),
    .cur_y          (cur_y),
    .err_acc        (err_acc),
    .delta_major    (delta_major),
    .delta_minor    (delta_minor),
    .dir            (dir),
    .remaining      (remaining),
    .next_x         (adv_x),
    .next_y         (adv_y),
    .next_err       (adv_err),
    .next_remaining (adv_remaining),
    .done           (adv_done)
  );

  // next line state and response contents
  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    err_acc_next     = err_acc;
    delta_major_next = delta_major;
    delta_minor_next = delta_minor;
    dir_next         = dir;
    remaining_next   = remaining;
    line_active_next = line_active;

    out_x_next      = out_x;
    out_y_next      = out_y;
    out_status_next = out_status;
    out_left_next   = out_left;
    out_last_next   = out_last;

    if (s1_fire) begin
      case (s1_req_type)
        bls_pkg::REQ_START: begin
          if (!su_accepted) begin
            // both endpoints outside: drop the line, keep the current point
            line_active_next = 1'b0;
            out_x_next       = '0;
            out_y_next       = '0;
            out_status_next  = bls_pkg::STATUS_REJECTED;
            out_left_next    = '0;
            out_last_next    = 1'b0;
          end else begin
            cur_x_next       = su_x;
            cur_y_next       = su_y;
            err_acc_next     = '0;
            delta_major_next = su_major;
            delta_minor_next = su_minor;
            dir_next         = su_dir;
            remaining_next   = su_major;
            // a single-point line is finished at once
            line_active_next = su_major != '0;
            out_x_next       = su_x;
            out_y_next       = su_y;
            out_status_next  = bls_pkg::STATUS_STARTED;
            out_left_next    = bls_pkg::LEFT_BITS'(su_major);
            out_last_next    = su_major == '0;
          end
        end
        bls_pkg::REQ_ADVANCE: begin
          if (!line_active) begin
            out_x_next      = cur_x;
            out_y_next      = cur_y;
            out_status_next = bls_pkg::STATUS_IDLE;
            out_left_next   = '0;
            out_last_next   = 1'b0;
          end else begin
            cur_x_next       = adv_x;
            cur_y_next       = adv_y;
            err_acc_next     = adv_err;
            remaining_next   = adv_remaining;
            line_active_next = !adv_done;
            out_x_next       = adv_x;
            out_y_next       = adv_y;
            out_status_next  = bls_pkg::STATUS_STEPPED;
            out_left_next    = bls_pkg::LEFT_BITS'(adv_remaining);
            out_last_next    = adv_done;
          end
        end
        default: begin
          out_status_next = bls_pkg::STATUS_IDLE;
        end
      endcase
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      err_acc     <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      dir         <= '0;
      remaining   <= '0;
      line_active <= 1'b0;
    end else begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      err_acc     <= err_acc_next;
      delta_major <= delta_major_next;
      delta_minor <= delta_minor_next;
      dir         <= dir_next;
      remaining   <= remaining_next;
      line_active <= line_active_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_x      <= out_x_next;
    out_y      <= out_y_next;
    out_status <= out_status_next;
    out_left   <= out_left_next;
    out_last   <= out_last_next;
  end
endmodule

[sv/bls_setup.sv]
// start decode: clipping test, endpoint swap, deltas and major axis
module bls_setup #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  logic signed [COORD_BITS-1:0]       begin_x,
  input  logic signed [COORD_BITS-1:0]       begin_y,
  input  logic signed [COORD_BITS-1:0]       end_x,
  input  logic signed [COORD_BITS-1:0]       end_y,
  input  logic [bls_pkg::DIM_BITS-1:0]       image_width,
  input  logic [bls_pkg::DIM_BITS-1:0]       image_height,
  output logic                               accepted,
  output logic signed [COORD_BITS-1:0]       org_x,
  output logic signed [COORD_BITS-1:0]       org_y,
  output bls_pkg::line_dir_t                 dir,
  output logic [COORD_BITS:0]                delta_major,
  output logic [COORD_BITS:0]                delta_minor
);
  localparam int CMP_BITS = (COORD_BITS > bls_pkg::DIM_BITS) ? COORD_BITS : bls_pkg::DIM_BITS;

  logic                         begin_in;
  logic                         end_in;
  logic signed [COORD_BITS-1:0] far_x;
  logic signed [COORD_BITS-1:0] far_y;
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]          adx;
  logic [COORD_BITS:0]          ady;

  function automatic logic in_range(input logic signed [COORD_BITS-1:0] v,
                                    input logic [bls_pkg::DIM_BITS-1:0] lim);
    logic [CMP_BITS-1:0] v_ext;
    logic [CMP_BITS-1:0] lim_ext;
    v_ext   = CMP_BITS'($unsigned(v));
    lim_ext = CMP_BITS'(lim);
    return !v[COORD_BITS-1] && (v_ext < lim_ext);
  endfunction

  always_comb begin
    begin_in = in_range(begin_x, image_width) && in_range(begin_y, image_height);
    end_in   = in_range(end_x, image_width) && in_range(end_y, image_height);
    accepted = begin_in || end_in;

    // draw from whichever endpoint is inside
    if (begin_in) begin
      org_x = begin_x;
      org_y = begin_y;
      far_x = end_x;
      far_y = end_y;
    end else begin
      org_x = end_x;
      org_y = end_y;
      far_x = begin_x;
      far_y = begin_y;
    end

    dx  = (COORD_BITS+1)'(far_x) - (COORD_BITS+1)'(org_x);
    dy  = (COORD_BITS+1)'(far_y) - (COORD_BITS+1)'(org_y);
    adx = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

    dir.x_negative = dx[COORD_BITS];
    dir.y_negative = dy[COORD_BITS];
    dir.x_is_major = adx > ady;  // tie goes to y
    delta_major    = dir.x_is_major ? adx : ady;
    delta_minor    = dir.x_is_major ? ady : adx;
  end
endmodule

[sv/bls_advance.sv]
// one error-accumulate step along the active line
module bls_advance #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic signed [COORD_BITS+1:0] err_acc,
  input  logic [COORD_BITS:0]          delta_major,
  input  logic [COORD_BITS:0]          delta_minor,
  input  bls_pkg::line_dir_t           dir,
  input  logic [COORD_BITS:0]          remaining,
  output logic signed [COORD_BITS-1:0] next_x,
  output logic signed [COORD_BITS-1:0] next_y,
  output logic signed [COORD_BITS+1:0] next_err,
  output logic [COORD_BITS:0]          next_remaining,
  output logic                         done
);
  logic signed [COORD_BITS+1:0] err_sum;
  logic signed [COORD_BITS+2:0] err_twice;
  logic signed [COORD_BITS+2:0] major_ext;
  logic                         minor_step;
  logic signed [COORD_BITS-1:0] step_x;
  logic signed [COORD_BITS-1:0] step_y;

  always_comb begin
    err_sum    = err_acc + $signed((COORD_BITS+2)'(delta_minor));
    err_twice  = $signed({err_sum, 1'b0});
    major_ext  = $signed((COORD_BITS+3)'(delta_major));
    minor_step = err_twice >= major_ext;

    step_x = dir.x_negative ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    step_y = dir.y_negative ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);

    next_err = minor_step ? err_sum - $signed((COORD_BITS+2)'(delta_major)) : err_sum;
    next_x   = (dir.x_is_major || minor_step) ? step_x : cur_x;
    next_y   = (!dir.x_is_major || minor_step) ? step_y : cur_y;

    next_remaining = remaining - (COORD_BITS+1)'(1);
    done           = next_remaining == '0;
  end
endmodule

[tb/tb_bresenham_line_stepper_unit.sv]
// testbench for the bresenham line stepper: directed table, then random lines checked by a predictor
module tb_bresenham_line_stepper_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB           = bls_pkg::COORD_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 490;
  localparam int DRAIN_CYCLES = 8;

  // one pixel transaction as it leaves the block
  typedef struct packed {
    logic signed [CB-1:0]          x;
    logic signed [CB-1:0]          y;
    bls_pkg::status_t              status;
    logic [bls_pkg::LEFT_BITS-1:0] left;
    logic                          last;
  } pixel_t;

  // directed plan: register write, start or advance; typed rows carry their own answer
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_START,
    ROW_ADVANCE
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    int               a;
    int               b;
    int               c;
    int               d;
    bit               typed;
    int               wx;
    int               wy;
    bls_pkg::status_t ws;
    int               wleft;
    bit               wlast;
  } plan_row_t;

  // for cfg rows a is the register index and b the write data
  localparam int PLAN_ROWS = 36;
  plan_row_t plan [PLAN_ROWS] = '{
    // advance straight out of reset: no line yet
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b1, 0, 0, bls_pkg::STATUS_IDLE, 0, 1'b0},
    // single-point line ends on its first pixel and leaves nothing active
    '{ROW_START, 0, 0, 0, 0, 1'b1, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b1},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b1, 0, 0, bls_pkg::STATUS_IDLE, 0, 1'b0},
    // both endpoints off the image
    '{ROW_START, -1, -1, 700, 500, 1'b1, 0, 0, bls_pkg::STATUS_REJECTED, 0, 1'b0},
    // shallow line, x major
    '{ROW_START, 10, 10, 20, 13, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // steep line, y major, x going down
    '{ROW_START, 5, 5, 2, 9, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // diagonal: a tie puts y on the major axis, walk it to its end and one past
    '{ROW_START, 0, 0, 3, 3, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // begin off the image: endpoints swap, drawing starts at the end point
    '{ROW_START, -5, 3, 4, 3, 1'b1, 4, 3, bls_pkg::STATUS_STARTED, 9, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // far corner of the default image toward the coordinate extremes
    '{ROW_START, 639, 479, -32768, 32767, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_START, 32767, -32768, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // largest image, upper data bit set and dropped
    '{ROW_CFG, bls_pkg::REG_IMAGE_WIDTH, 16'hffff, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, bls_pkg::REG_IMAGE_HEIGHT, 16'h7fff, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    // longest possible line
    '{ROW_START, 32766, 32766, -32768, -32768, 1'b1, 32766, 32766,
      bls_pkg::STATUS_STARTED, 65534, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // zero width: everything rejected, current point kept for the next advance
    '{ROW_CFG, bls_pkg::REG_IMAGE_WIDTH, 0, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_START, 0, 0, 0, 0, 1'b1, 0, 0, bls_pkg::STATUS_REJECTED, 0, 1'b0},
    '{ROW_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    // tiny image, unknown register indexes must not disturb anything
    '{ROW_CFG, bls_pkg::REG_IMAGE_WIDTH, 16'h8005, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, bls_pkg::REG_IMAGE_HEIGHT, 1, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, 2, 16'h1234, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, 255, 16'hffff, 0, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_START, 4, 0, -3, 0, 1'b1, 4, 0, bls_pkg::STATUS_STARTED, 7, 1'b0},
    // x equal to width is outside, and the end point lies beyond it: both ends off
    '{ROW_START, 5, 0, 9, 0, 1'b1, 0, 0, bls_pkg::STATUS_REJECTED, 0, 1'b0},
    '{ROW_START, 0, 1, 4, 0, 1'b0, 0, 0, bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, bls_pkg::REG_IMAGE_WIDTH, 640, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0},
    '{ROW_CFG, bls_pkg::REG_IMAGE_HEIGHT, 16'h81e0, 0, 0, 1'b0, 0, 0,
      bls_pkg::STATUS_STARTED, 0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  bls_req_if #(.COORD_BITS(CB)) req_ch ();
  bls_rsp_if #(.COORD_BITS(CB)) rsp_ch ();
  bls_cfg_if                    cfg_ch ();

  bresenham_line_stepper_unit #(.COORD_BITS(CB)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the image size and the line walker state
  int                   width_px   = bls_pkg::IMAGE_WIDTH_RESET;
  int                   height_px  = bls_pkg::IMAGE_HEIGHT_RESET;
  logic signed [CB-1:0] pen_x      = '0;
  logic signed [CB-1:0] pen_y      = '0;
  int                   err_sum    = 0;
  int                   major_len  = 0;
  int                   minor_len  = 0;
  bit                   neg_x      = 1'b0;
  bit                   neg_y      = 1'b0;
  bit                   x_major    = 1'b0;
  int                   steps_left = 0;
  bit                   drawing    = 1'b0;

  // pixels still owed by the block, oldest first
  pixel_t pending_pixels [$];

  int  mismatches     = 0;
  int  directed_items = 0;
  int  random_items   = 0;
  int  reg_writes     = 0;
  int  seen_status [4] = '{0, 0, 0, 0};
  // set per phase: both sides run without gaps
  bit  steady = 1'b0;

  function automatic bit on_image(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py);
    return int'(px) >= 0 && int'(px) < width_px && int'(py) >= 0 && int'(py) < height_px;
  endfunction

  // one request through the line walker: start latches a new line, advance takes one step
  function automatic pixel_t trace_step(input bls_pkg::req_type_t kind,
                                        input logic signed [CB-1:0] bx,
                                        input logic signed [CB-1:0] by,
                                        input logic signed [CB-1:0] ex,
                                        input logic signed [CB-1:0] ey);
    pixel_t               r;
    int                   dx;
    int                   dy;
    int                   adx;
    int                   ady;
    bit                   b_in;
    bit                   e_in;
    logic signed [CB-1:0] step_x;
    logic signed [CB-1:0] step_y;
    r = '{x: '0, y: '0, status: bls_pkg::STATUS_STARTED, left: '0, last: 1'b0};
    if (kind == bls_pkg::REQ_START) begin
      b_in = on_image(bx, by);
      e_in = on_image(ex, ey);
      if (!b_in && !e_in) begin
        drawing  = 1'b0;
        r.status = bls_pkg::STATUS_REJECTED;
        return r;
      end
      // always draw from the endpoint that is on the image
      if (b_in) begin
        pen_x = bx;
        pen_y = by;
        dx    = int'(ex) - int'(bx);
        dy    = int'(ey) - int'(by);
      end else begin
        pen_x = ex;
        pen_y = ey;
        dx    = int'(bx) - int'(ex);
        dy    = int'(by) - int'(ey);
      end
      neg_x      = dx < 0;
      neg_y      = dy < 0;
      adx        = neg_x ? -dx : dx;
      ady        = neg_y ? -dy : dy;
      x_major    = adx > ady;
      major_len  = x_major ? adx : ady;
      minor_len  = x_major ? ady : adx;
      steps_left = major_len;
      err_sum    = 0;
      drawing    = steps_left != 0;
      r.x        = pen_x;
      r.y        = pen_y;
      r.left     = steps_left[bls_pkg::LEFT_BITS-1:0];
      r.last     = steps_left == 0;
    end else if (!drawing) begin
      r.x      = pen_x;
      r.y      = pen_y;
      r.status = bls_pkg::STATUS_IDLE;
    end else begin
      step_x  = neg_x ? CB'(-1) : CB'(1);
      step_y  = neg_y ? CB'(-1) : CB'(1);
      err_sum = err_sum + minor_len;
      if (2 * err_sum >= major_len) begin
        if (x_major) pen_y = pen_y + step_y;
        else pen_x = pen_x + step_x;
        err_sum = err_sum - major_len;
      end
      if (x_major) pen_x = pen_x + step_x;
      else pen_y = pen_y + step_y;
      steps_left = steps_left - 1;
      if (steps_left <= 0) begin
        steps_left = 0;
        drawing    = 1'b0;
      end
      r.x      = pen_x;
      r.y      = pen_y;
      r.status = bls_pkg::STATUS_STEPPED;
      r.left   = steps_left[bls_pkg::LEFT_BITS-1:0];
      r.last   = steps_left == 0;
    end
    return r;
  endfunction

  // present one request, wait for the transaction, then log what it must produce
  task automatic offer_request(input bls_pkg::req_type_t kind,
                               input logic signed [CB-1:0] bx,
                               input logic signed [CB-1:0] by,
                               input logic signed [CB-1:0] ex,
                               input logic signed [CB-1:0] ey,
                               input bit typed,
                               input pixel_t want);
    int     gap;
    pixel_t predicted;
    gap = steady ? 0 : $urandom_range(0, 3);
    // valid only drops when a gap follows, so it never toggles within one step
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.begin_x  <= bx;
    req_ch.begin_y  <= by;
    req_ch.end_x    <= ex;
    req_ch.end_y    <= ey;
    do @(posedge clk); while (!req_ch.ready);
    predicted = trace_step(kind, bx, by, ex, ey);
    pending_pixels.push_back(typed ? want : predicted);
  endtask

  // register writes only once the block has drained
  task automatic write_register(input logic [bls_pkg::CFG_ADDR_BITS-1:0] idx,
                                input logic [bls_pkg::CFG_DATA_BITS-1:0] val);
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // let the request and response registers empty
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    // upper data bit is dropped, unknown indexes are ignored
    case (idx)
      bls_pkg::REG_IMAGE_WIDTH:  width_px  = int'(val[bls_pkg::DIM_BITS-1:0]);
      bls_pkg::REG_IMAGE_HEIGHT: height_px = int'(val[bls_pkg::DIM_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name,
                               input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // response side: random stalls, every pixel transaction checked against the oldest pending one
  initial begin : pixel_sink
    int     stall;
    pixel_t got;
    pixel_t want;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got.x      = rsp_ch.pixel_x;
      got.y      = rsp_ch.pixel_y;
      got.status = bls_pkg::status_t'(rsp_ch.status);
      got.left   = rsp_ch.pixels_left;
      got.last   = rsp_ch.is_last;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel transaction, expected none, actual x=%0d y=%0d status=%0d",
                 $time, got.x, got.y, got.status);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        seen_status[want.status]++;
        compare_field("pixel_x", want.x, got.x);
        compare_field("pixel_y", want.y, got.y);
        compare_field("status", {30'd0, want.status}, {30'd0, rsp_ch.status});
        compare_field("pixels_left", {16'd0, want.left}, {16'd0, got.left});
        compare_field("is_last", {31'd0, want.last}, {31'd0, rsp_ch.is_last});
      end
    end
  end

  // stimulus: reset, directed table, then phases of random image sizes and lines
  initial begin : line_source
    int                 w;
    int                 h;
    int                 bx;
    int                 by;
    int                 ex;
    int                 ey;
    int                 tmp;
    int                 span;
    int                 n;
    int                 phase_end;
    plan_row_t          row;
    pixel_t             want;
    bls_pkg::req_type_t kind;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= bls_pkg::REQ_START;
    req_ch.begin_x  <= '0;
    req_ch.begin_y  <= '0;
    req_ch.end_x    <= '0;
    req_ch.end_y    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.addr     <= '0;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.a[bls_pkg::CFG_ADDR_BITS-1:0], row.b[bls_pkg::CFG_DATA_BITS-1:0]);
      end else begin
        want.x      = row.wx[CB-1:0];
        want.y      = row.wy[CB-1:0];
        want.status = row.ws;
        want.left   = row.wleft[bls_pkg::LEFT_BITS-1:0];
        want.last   = row.wlast;
        kind        = (row.kind == ROW_START) ? bls_pkg::REQ_START : bls_pkg::REQ_ADVANCE;
        offer_request(kind, row.a[CB-1:0], row.b[CB-1:0], row.c[CB-1:0], row.d[CB-1:0],
                      row.typed, want);
        directed_items++;
      end
    end

    // random part: each phase sets a new image size, then mostly well-formed lines
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin
          w = bls_pkg::IMAGE_WIDTH_RESET;
          h = bls_pkg::IMAGE_HEIGHT_RESET;
        end
        1: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 16);
        end
        2: begin
          w = 32767;
          h = 32767;
        end
        3: begin
          w = 1;
          h = $urandom_range(1, 100);
        end
        4: begin
          // raw 16-bit data: may leave a zero-sized image
          w = $urandom_range(0, 65535);
          h = $urandom_range(0, 65535);
        end
        default: begin
          w = $urandom_range(1, 300);
          h = $urandom_range(1, 300);
        end
      endcase
      write_register(bls_pkg::REG_IMAGE_WIDTH, w[bls_pkg::CFG_DATA_BITS-1:0]);
      write_register(bls_pkg::REG_IMAGE_HEIGHT, h[bls_pkg::CFG_DATA_BITS-1:0]);
      if ($urandom_range(0, 3) == 0) begin
        tmp = $urandom_range(2, 255);
        n   = $urandom;
        write_register(tmp[bls_pkg::CFG_ADDR_BITS-1:0], n[bls_pkg::CFG_DATA_BITS-1:0]);
      end
      w         = width_px;
      h         = height_px;
      steady    = ($urandom_range(0, 3) == 0);
      phase_end = random_items + $urandom_range(40, 90);
      while (random_items < phase_end) begin
        if (w > 0 && h > 0 && $urandom_range(0, 3) != 0) begin
          // short line from a point on the image, sometimes drawn from the far end
          span = ($urandom_range(0, 3) == 0) ? 40 : 8;
          bx   = $urandom_range(0, w - 1);
          by   = $urandom_range(0, h - 1);
          tmp  = $urandom_range(0, 2 * span);
          ex   = bx + tmp - span;
          tmp  = $urandom_range(0, 2 * span);
          ey   = by + tmp - span;
          if ($urandom_range(0, 3) == 0) begin
            tmp = bx; bx = ex; ex = tmp;
            tmp = by; by = ey; ey = tmp;
          end
          offer_request(bls_pkg::REQ_START, bx[CB-1:0], by[CB-1:0], ex[CB-1:0], ey[CB-1:0],
                        1'b0, '0);
          random_items++;
          // usually walk past the end, sometimes abandon the line early
          n = steps_left + $urandom_range(0, 2);
          if ($urandom_range(0, 4) == 0) n = $urandom_range(0, steps_left);
          repeat (n) begin
            tmp = $urandom;
            offer_request(bls_pkg::REQ_ADVANCE, tmp[CB-1:0], tmp[31:16], tmp[CB-1:0],
                          tmp[31:16], 1'b0, '0);
            random_items++;
          end
        end else begin
          // noise: either request with coordinates near the image or anywhere
          if ($urandom_range(0, 1) == 0) begin
            bx = $urandom_range(0, w + 20) - 10;
            by = $urandom_range(0, h + 20) - 10;
            ex = $urandom_range(0, w + 20) - 10;
            ey = $urandom_range(0, h + 20) - 10;
          end else begin
            bx = $urandom;
            by = $urandom;
            ex = $urandom;
            ey = $urandom;
          end
          tmp  = $urandom;
          kind = tmp[0] ? bls_pkg::REQ_ADVANCE : bls_pkg::REQ_START;
          offer_request(kind, bx[CB-1:0], by[CB-1:0], ex[CB-1:0], ey[CB-1:0], 1'b0, '0);
          random_items++;
        end
      end
    end

    // drain, then a few quiet cycles to catch anything extra
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d directed and %0d random requests across %0d register writes",
             directed_items, random_items, reg_writes);
    $display("saw %0d starts, %0d rejects, %0d steps, %0d advances with no line",
             seen_status[bls_pkg::STATUS_STARTED], seen_status[bls_pkg::STATUS_REJECTED],
             seen_status[bls_pkg::STATUS_STEPPED], seen_status[bls_pkg::STATUS_IDLE]);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
